/* design/wmmd_pkg.sv */
// types, widths and constants shared by the min/max peak decimator
`default_nettype none
package wmmd_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int POS_W       = 20;
	localparam int LEN_W       = POS_W + 1;
	localparam int COLS_W      = 13;
	localparam int COL_W       = 12;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = LEN_W;
	localparam int DIV_STEPS   = LEN_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

	localparam int MAX_COLUMNS    = 4096;
	localparam int MIN_PER_COLUMN = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 2'd2;

	localparam logic [POS_W-1:0]  WINDOW_START_RST  = '0;
	localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST = LEN_W'(1024);
	localparam logic [COLS_W-1:0] COLUMN_COUNT_RST  = COLS_W'(512);
	localparam logic [POS_W-1:0]  BUCKET_LEN_RST    = POS_W'(1024 / 512);
	localparam logic              DECIMATE_RST      = (1024 / MIN_PER_COLUMN) >= 512;

	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(1) << POS_W;
	localparam logic [LEN_W-1:0]  POS_MAX  = '1;
	localparam logic [POS_W-1:0]  QUO_MAX  = '1;
	localparam logic [COLS_W-1:0] COLS_MAX = COLS_W'(MAX_COLUMNS);

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       buffer_start;
	} in_beat_t;

	typedef struct packed {
		logic [POS_W-1:0]           slot_index;
		logic signed [SAMPLE_W-1:0] peak_high;
		logic signed [SAMPLE_W-1:0] peak_low;
		logic                       decimated;
		logic                       last;
	} out_beat_t;

endpackage
`default_nettype wire

/* design/waveform_min_max_decimator.sv */
// top level of the min/max peak decimator for waveform display
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  in       | in_valid / in_ready    | in_data  (sample, buffer_start)
//  out      | out_valid / out_ready  | out_data (slot, high, low, mode, last)
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one beat per cycle unless stalled: input register, compare and count logic,
//  then the result register
//  a register write starts a restoring divider for the bucket length
//  (one quotient bit a cycle) that holds in_ready low
//  reset leaves the derived values of the reset registers in place at once
//  out_ready low stalls the result register and in turn the input register
`default_nettype none
module waveform_min_max_decimator (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wmmd_pkg::in_beat_t               in_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output wmmd_pkg::out_beat_t              out_data,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [wmmd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [wmmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import wmmd_pkg::*;

	// configuration and derived values
	logic [POS_W-1:0]  window_start_q;
	logic [LEN_W-1:0]  window_length_q;
	logic [COLS_W-1:0] column_count_q;
	logic [POS_W-1:0]  bucket_len_q;
	logic              decimate_q;
	logic [LEN_W-1:0]  eff_len;
	logic [COLS_W-1:0] eff_cols;
	logic [COL_W-1:0]  last_col;
	logic [COLS_W+2:0] cols_x5;
	logic              cfg_hit;

	// divider
	logic                 div_start_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [LEN_W-1:0]     div_dvd_q;
	logic [COL_W:0]       div_rem_q;
	logic                 div_busy;
	logic [COL_W+1:0]     div_trial;
	logic                 div_qbit;
	logic [LEN_W-1:0]     div_dvd_nxt;

	// datapath
	in_beat_t          in_s1;
	logic              valid_s1;
	logic              adv;
	logic              out_valid_q;
	out_beat_t         out_data_q;
	logic [LEN_W-1:0]  position_q;
	logic [COL_W-1:0]  column_q;
	logic [LEN_W-1:0]  fill_q;
	logic signed [SAMPLE_W-1:0] high_q;
	logic signed [SAMPLE_W-1:0] low_q;

	logic [LEN_W-1:0]  pos_cur;
	logic [COL_W-1:0]  col_base;
	logic [LEN_W-1:0]  fill_base;
	logic signed [SAMPLE_W-1:0] high_base;
	logic signed [SAMPLE_W-1:0] low_base;
	logic [LEN_W:0]    win_end;
	logic              visible;
	logic [LEN_W-1:0]  offset;
	logic              at_end;
	logic signed [SAMPLE_W-1:0] high_new;
	logic signed [SAMPLE_W-1:0] low_new;
	logic [LEN_W-1:0]  fill_new;
	logic [COL_W-1:0]  col_sat;
	logic              col_open;
	logic              emit;
	out_beat_t         result;

	assign eff_len  = (window_length_q > LEN_MAX) ? LEN_MAX : window_length_q;
	assign eff_cols = (column_count_q == '0) ? COLS_W'(1) :
		(column_count_q > COLS_MAX) ? COLS_MAX : column_count_q;
	assign last_col = COL_W'(eff_cols - COLS_W'(1));
	assign cols_x5  = {1'b0, eff_cols, 2'b00} + {3'b000, eff_cols};

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_WINDOW_START ||
		cfg_index == CFG_WINDOW_LENGTH || cfg_index == CFG_COLUMN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q  <= WINDOW_START_RST;
			window_length_q <= WINDOW_LENGTH_RST;
			column_count_q  <= COLUMN_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WINDOW_START:  window_start_q  <= cfg_data[POS_W-1:0];
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data[LEN_W-1:0];
				CFG_COLUMN_COUNT:  column_count_q  <= cfg_data[COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// restoring divider: eff_len / eff_cols, one quotient bit a cycle
	assign div_busy    = div_start_q || (div_cnt_q != '0);
	assign div_trial   = {div_rem_q, div_dvd_q[LEN_W-1]};
	assign div_qbit    = div_trial >= {1'b0, eff_cols};
	assign div_dvd_nxt = {div_dvd_q[LEN_W-2:0], div_qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_start_q  <= 1'b0;
			div_cnt_q    <= '0;
			bucket_len_q <= BUCKET_LEN_RST;
			decimate_q   <= DECIMATE_RST;
		end else if (cfg_hit) begin
			div_start_q <= 1'b1;
			div_cnt_q   <= '0;
		end else if (div_start_q) begin
			div_start_q <= 1'b0;
			div_cnt_q   <= DIV_CNT_W'(DIV_STEPS);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
			if (div_cnt_q == DIV_CNT_W'(1)) begin
				bucket_len_q <= div_dvd_nxt[LEN_W-1] ? QUO_MAX : div_dvd_nxt[POS_W-1:0];
				decimate_q   <= eff_len >= LEN_W'(cols_x5);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start_q) begin
			div_dvd_q <= eff_len;
			div_rem_q <= '0;
		end else if (div_cnt_q != '0) begin
			div_dvd_q <= div_dvd_nxt;
			div_rem_q <= div_qbit ? (COL_W+1)'(div_trial - {1'b0, eff_cols}) :
				div_trial[COL_W:0];
		end
	end

	// handshake
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !div_busy && (!valid_s1 || adv);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// per-beat window, bucket and peak logic
	always_comb begin
		pos_cur   = in_s1.buffer_start ? '0 : position_q;
		col_base  = in_s1.buffer_start ? '0 : column_q;
		fill_base = in_s1.buffer_start ? '0 : fill_q;
		high_base = in_s1.buffer_start ? SAMPLE_MIN : high_q;
		low_base  = in_s1.buffer_start ? SAMPLE_MAX : low_q;

		win_end = {2'b00, window_start_q} + {1'b0, eff_len};
		visible = (eff_len != '0) && (pos_cur >= {1'b0, window_start_q}) &&
			({1'b0, pos_cur} < win_end);
		offset  = pos_cur - {1'b0, window_start_q};
		at_end  = offset == (eff_len - LEN_W'(1));

		high_new = (in_s1.sample > high_base) ? in_s1.sample : high_base;
		low_new  = (in_s1.sample < low_base) ? in_s1.sample : low_base;
		fill_new = (fill_base < POS_MAX) ? fill_base + LEN_W'(1) : fill_base;
		col_sat  = (col_base > last_col) ? last_col : col_base;
		col_open = col_sat < last_col;

		emit = visible && (!decimate_q || at_end ||
			(col_open && fill_new >= {1'b0, bucket_len_q}));

		result.slot_index = decimate_q ? POS_W'(col_sat) : offset[POS_W-1:0];
		result.peak_high  = decimate_q ? high_new : in_s1.sample;
		result.peak_low   = decimate_q ? low_new : in_s1.sample;
		result.decimated  = decimate_q;
		result.last       = at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			position_q  <= '0;
			column_q    <= '0;
			fill_q      <= '0;
			high_q      <= SAMPLE_MIN;
			low_q       <= SAMPLE_MAX;
		end else if (adv) begin
			out_valid_q <= valid_s1 && emit;
			if (valid_s1) begin
				position_q <= (pos_cur < POS_MAX) ? pos_cur + LEN_W'(1) : pos_cur;
				if (visible && decimate_q) begin
					if (emit) begin
						column_q <= col_open ? col_sat + COL_W'(1) : col_sat;
						fill_q   <= '0;
						high_q   <= SAMPLE_MIN;
						low_q    <= SAMPLE_MAX;
					end else begin
						column_q <= col_sat;
						fill_q   <= fill_new;
						high_q   <= high_new;
						low_q    <= low_new;
					end
				end else begin
					column_q <= col_base;
					fill_q   <= fill_base;
					high_q   <= high_base;
					low_q    <= low_base;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= result;
		end
	end

endmodule
`default_nettype wire
